// ===== rtl/imu_complementary_tilt_filter_macros.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctf_pkg.sv =====
package ctf_pkg;

  localparam int DEN_W        = 26;  // sensitivity * 1000
  localparam int MAG_W        = 49;  // |rate - bias| * dt
  localparam int QUOT_W       = 34;  // clipped increment magnitude
  localparam int DIV_STEPS    = MAG_W + 16;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 23;
  localparam int CORD_W       = 36;

  // register map, index = byte address / 4
  localparam logic [2:0] REG_BIAS_X = 3'd0;
  localparam logic [2:0] REG_BIAS_Y = 3'd1;
  localparam logic [2:0] REG_BIAS_Z = 3'd2;
  localparam logic [2:0] REG_SENS   = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ctf_div.sv =====
// Restoring divider, one quotient bit per cycle: floor((num << 16) / den).
// Quotient clipped to all ones when it exceeds QUOT_W bits.
module ctf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ctf_pkg::MAG_W-1:0]        num,
  input  logic [ctf_pkg::DEN_W-1:0]        den,
  output logic                             done,
  output logic [ctf_pkg::QUOT_W-1:0]       quot
);

  logic                               busy_r;
  logic                               done_r;
  logic [6:0]                         cnt_r;
  logic [ctf_pkg::DIV_STEPS-1:0]      n_r;
  logic [ctf_pkg::DEN_W:0]            rem_r;
  logic [ctf_pkg::QUOT_W-1:0]         q_r;
  logic                               ovf_r;
  logic [ctf_pkg::DEN_W:0]            rem_sh;
  logic                               fits;

  assign rem_sh = {rem_r[ctf_pkg::DEN_W-1:0], n_r[ctf_pkg::DIV_STEPS-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'(ctf_pkg::DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(ctf_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {num, 16'b0};
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      n_r   <= {n_r[ctf_pkg::DIV_STEPS-2:0], 1'b0};
      rem_r <= fits ? rem_sh - {1'b0, den} : rem_sh;
      ovf_r <= ovf_r | q_r[ctf_pkg::QUOT_W-1];
      q_r   <= {q_r[ctf_pkg::QUOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = ovf_r ? '1 : q_r;

endmodule

// ===== rtl/ctf_isqrt.sv =====
// Digit-by-digit square root of (rad << 32), two radicand bits per cycle.
module ctf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] n_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        fits;

  assign rem_sh = {rem_r[32:0], n_r[31:30]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'(ctf_pkg::SQRT_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ctf_pkg::SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[29:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/ctf_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per cycle; z is the angle of
// (x0, num * 2^16) in Q16 degrees. Zero vector gives zero.
module ctf_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        x0,
  input  logic signed [16:0] num,
  output logic               done,
  output logic signed [31:0] angle
);

  logic                                busy_r;
  logic                                done_r;
  logic [4:0]                          cnt_r;
  logic signed [ctf_pkg::CORD_W-1:0]   x_r;
  logic signed [ctf_pkg::CORD_W-1:0]   y_r;
  logic signed [31:0]                  z_r;
  logic                                zero_r;
  logic signed [ctf_pkg::CORD_W-1:0]   xs;
  logic signed [ctf_pkg::CORD_W-1:0]   ys;
  logic signed [31:0]                  step;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign step = $signed({10'b0, ctf_pkg::atan_q16(cnt_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'(ctf_pkg::CORDIC_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ctf_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= $signed({4'b0, x0});
      y_r    <= $signed({{3{num[16]}}, num, 16'b0});
      z_r    <= '0;
      zero_r <= (x0 == 32'd0) && (num == 17'sd0);
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step;
      end
    end
  end

  assign done  = done_r;
  assign angle = zero_r ? 32'sd0 : z_r;

endmodule

// ===== rtl/imu_complementary_tilt_filter.sv =====
// Complementary tilt filter: one result transaction per input transaction.
// Each sample runs three divisions for the gyro increments, then two square
// roots and two CORDIC runs for the tilt angles, plus shared-multiplier steps.
// One sample at a time: in_tready is high only while idle.
// Reset (rst_n low, synchronous) clears angles and timestamp, biases to 0,
// sensitivity to 131 and weight to 62915; no clearing pass.
`include "imu_complementary_tilt_filter_macros.svh"

module imu_complementary_tilt_filter (
  input  logic         clk,
  input  logic         rst_n,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, sample_time_ms
  input  logic [127:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // angle_x, angle_y, angle_z
  output logic [95:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_DEN  = 12'b000000000010,
    ST_RMUL = 12'b000000000100,
    ST_DIV  = 12'b000000001000,
    ST_SQA  = 12'b000000010000,
    ST_SQB  = 12'b000000100000,
    ST_SQRT = 12'b000001000000,
    ST_CORD = 12'b000010000000,
    ST_BLA  = 12'b000100000000,
    ST_BLB  = 12'b001000000000,
    ST_BLS  = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] bias_x_r, bias_y_r, bias_z_r;
  logic [15:0]        sens_r;
  logic [16:0]        weight_r;

  // filter state
  logic signed [31:0] held_x_r, held_y_r, held_z_r;
  logic [31:0]        held_time_r;

  // latched sample
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [31:0]        dt_r;

  // working registers
  logic [1:0]                    axis_r;
  logic                          tilt_r;
  logic [ctf_pkg::DEN_W-1:0]     den_r;
  logic                          neg_r;
  logic signed [31:0]            gyro_r [3];
  logic signed [31:0]            tilt_ang_r [2];  // accel angle, then blended
  logic signed [51:0]            acc_r;

  logic [95:0] out_tdata_r;
  logic        out_tvalid_r;

  // handshakes
  logic in_fire, cfg_wr, out_load;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_load   = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // --- per-axis gyro term -------------------------------------------------
  logic signed [15:0] rate_sel, bias_sel;
  logic signed [31:0] held_sel;
  logic signed [16:0] rdiff;
  logic [16:0]        rabs;

  always_comb begin
    case (axis_r)
      2'd0: begin
        rate_sel = gx_r; bias_sel = bias_x_r; held_sel = held_x_r;
      end
      2'd1: begin
        rate_sel = gy_r; bias_sel = bias_y_r; held_sel = held_y_r;
      end
      default: begin
        rate_sel = gz_r; bias_sel = bias_z_r; held_sel = held_z_r;
      end
    endcase
  end

  assign rdiff = {rate_sel[15], rate_sel} - {bias_sel[15], bias_sel};
  assign rabs  = rdiff[16] ? 17'(-rdiff) : rdiff;

  // --- tilt operands --------------------------------------------------------
  logic signed [15:0] sq_a;
  logic signed [16:0] tilt_num;
  assign sq_a     = tilt_r ? ay_r : ax_r;
  assign tilt_num = tilt_r ? 17'(-{ax_r[15], ax_r}) : {ay_r[15], ay_r};

  logic [15:0] sens_eff;
  logic [16:0] w_eff;
  assign sens_eff = (sens_r == 16'd0) ? 16'd1 : sens_r;
  assign w_eff    = (weight_r > 17'd65536) ? 17'd65536 : weight_r;

  // --- shared multiplier: denominator, rate*dt, squares, blend weights ----
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod;

  always_comb begin
    case (state_r)
      ST_DEN: begin
        mul_a = $signed({2'b0, sens_eff});
        mul_b = 34'sd1000;
      end
      ST_RMUL: begin
        mul_a = $signed({1'b0, rabs});
        mul_b = $signed({2'b0, dt_r});
      end
      ST_SQA: begin
        mul_a = 18'(sq_a);
        mul_b = 34'(sq_a);
      end
      ST_SQB: begin
        mul_a = 18'(az_r);
        mul_b = 34'(az_r);
      end
      ST_BLA: begin
        mul_a = $signed({1'b0, w_eff});
        mul_b = 34'(gyro_r[tilt_r]);
      end
      ST_BLB: begin
        mul_a = $signed({1'b0, 17'(17'd65536 - w_eff)});
        mul_b = 34'(tilt_ang_r[tilt_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // --- iterative units ------------------------------------------------------
  logic                          div_start, div_done;
  logic [ctf_pkg::QUOT_W-1:0]    quot;
  logic                          sqrt_start, sqrt_done;
  logic [31:0]                   root;
  logic                          cord_start, cord_done;
  logic signed [31:0]            cord_angle;

  assign div_start  = (state_r == ST_RMUL);
  assign sqrt_start = (state_r == ST_SQB);
  assign cord_start = (state_r == ST_SQRT) && sqrt_done;

  ctf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod[ctf_pkg::MAG_W-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  ctf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (32'(acc_r + prod)),  // a^2 + b^2
    .done  (sqrt_done),
    .root  (root)
  );

  ctf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x0    (root),
    .num   (tilt_num),
    .done  (cord_done),
    .angle (cord_angle)
  );

  // gyro estimate: held +/- increment, saturated
  logic signed [35:0] gsum;
  logic signed [35:0] qinc;
  assign qinc = $signed({2'b0, quot});
  assign gsum = 36'(held_sel) + (neg_r ? -qinc : qinc);

  // blend: round to nearest, floor shift
  logic signed [51:0] bsum;
  assign bsum = acc_r + 52'sd32768;

  // --- sequencer ------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_RMUL;
      ST_RMUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = (axis_r == 2'd2) ? ST_SQA : ST_RMUL;
      end
      ST_SQA:  state_nxt = ST_SQB;
      ST_SQB:  state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_nxt = ST_CORD;
      ST_CORD: begin
        if (cord_done) state_nxt = tilt_r ? ST_BLA : ST_SQA;
      end
      ST_BLA:  state_nxt = ST_BLB;
      ST_BLB:  state_nxt = ST_BLS;
      ST_BLS:  state_nxt = tilt_r ? ST_OUT : ST_BLA;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      held_x_r     <= '0;
      held_y_r     <= '0;
      held_z_r     <= '0;
      held_time_r  <= '0;
      bias_x_r     <= '0;
      bias_y_r     <= '0;
      bias_z_r     <= '0;
      sens_r       <= 16'd131;
      weight_r     <= 17'd62915;
      axis_r       <= '0;
      tilt_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          ctf_pkg::REG_BIAS_X: bias_x_r <= cfg_pwdata[15:0];
          ctf_pkg::REG_BIAS_Y: bias_y_r <= cfg_pwdata[15:0];
          ctf_pkg::REG_BIAS_Z: bias_z_r <= cfg_pwdata[15:0];
          ctf_pkg::REG_SENS:   sens_r   <= cfg_pwdata[15:0];
          ctf_pkg::REG_WEIGHT: weight_r <= cfg_pwdata[16:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        held_time_r <= in_tdata[127:96];
        axis_r      <= '0;
        tilt_r      <= 1'b0;
      end
      if ((state_r == ST_DIV) && div_done && (axis_r != 2'd2)) begin
        axis_r <= axis_r + 2'd1;
      end
      if (((state_r == ST_CORD) && cord_done) || (state_r == ST_BLS)) begin
        tilt_r <= ~tilt_r;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        held_x_r     <= tilt_ang_r[0];
        held_y_r     <= tilt_ang_r[1];
        held_z_r     <= gyro_r[2];
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
      gx_r <= in_tdata[63:48];
      gy_r <= in_tdata[79:64];
      gz_r <= in_tdata[95:80];
      dt_r <= in_tdata[127:96] - held_time_r;  // wraps mod 2^32
    end
    case (state_r)
      ST_DEN:  den_r <= prod[ctf_pkg::DEN_W-1:0];
      ST_RMUL: neg_r <= rdiff[16];
      ST_DIV:  if (div_done) gyro_r[axis_r] <= ctf_pkg::sat32(gsum);
      ST_SQA:  acc_r <= prod;
      ST_CORD: if (cord_done) tilt_ang_r[tilt_r] <= cord_angle;
      ST_BLA:  acc_r <= prod;
      ST_BLB:  acc_r <= acc_r + prod;
      ST_BLS:  tilt_ang_r[tilt_r] <= ctf_pkg::sat32(bsum[51:16]);
      default: ;
    endcase
    if (out_load) begin
      out_tdata_r <= {gyro_r[2], tilt_ang_r[1], tilt_ang_r[0]};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // register readback
  always_comb begin
    case (cfg_paddr[4:2])
      ctf_pkg::REG_BIAS_X: cfg_prdata = 32'(bias_x_r);
      ctf_pkg::REG_BIAS_Y: cfg_prdata = 32'(bias_y_r);
      ctf_pkg::REG_BIAS_Z: cfg_prdata = 32'(bias_z_r);
      ctf_pkg::REG_SENS:   cfg_prdata = {16'b0, sens_r};
      ctf_pkg::REG_WEIGHT: cfg_prdata = {15'b0, weight_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // one item at a time: an accepted transaction closes the input
  `CTF_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "input open while busy")
  // timestamp is held from the accepted sample
  `CTF_ASSERT_NEXT(a_time_held, in_fire, held_time_r == $past(in_tdata[127:96]),
                   "held timestamp mismatch")
  // a fresh result carries the new held yaw
  `CTF_ASSERT_NOW(a_yaw_held, $rose(out_tvalid), out_tdata[95:64] == held_z_r,
                  "result yaw differs from held yaw")

endmodule
